// File: hw/rtl/best_shot_lane_selector_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the best shot lane selector
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef BEST_SHOT_LANE_SELECTOR_CORE_ASSERT_SVH
`define BEST_SHOT_LANE_SELECTOR_CORE_ASSERT_SVH

// Checked only while reset is low.
`define BSLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define BSLS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/bsls_pkg.sv
// ---------------------------------------------------------------------------
// Best shot lane selector package
// Shared widths, register indexes and constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsls_pkg;

  localparam int NUM_W = 51;   // |cross| * isqrt(v.v) numerator
  localparam int DEN_W = 35;   // projection e.v
  localparam int Q_W   = 16;   // lane score

  localparam logic [Q_W-1:0] SCORE_MAX = 16'hFFFF;

  localparam logic [2:0] CFG_GOAL_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_GOAL_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_MOUTH_WIDTH     = 3'd2;
  localparam logic [2:0] CFG_BLOCK_RADIUS_MM = 3'd3;
  localparam logic [2:0] CFG_STEP_MM         = 3'd4;

  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_BLOCKED  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic OP_ADD = 1'b0;

  typedef logic [Q_W-1:0] score_t;

endpackage

// File: hw/rtl/bsls_div.sv
// ---------------------------------------------------------------------------
// Lane score divider
// Restoring divider, one quotient bit a cycle, saturating at the score limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsls_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bsls_pkg::NUM_W-1:0] num,
  input  logic [bsls_pkg::DEN_W-1:0] den,
  output logic                       done,
  output bsls_pkg::score_t           quot
);
  import bsls_pkg::*;

  logic             busy;
  logic [3:0]       cnt;
  logic [NUM_W-1:0] rem;
  logic [NUM_W-1:0] dsh;
  logic             ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // A quotient that cannot fit in sixteen bits saturates at once.
        if (num >= {den, 16'b0}) begin
          quot <= SCORE_MAX;
          done <= 1'b1;
        end else begin
          rem  <= num;
          dsh  <= {1'b0, den, 15'b0};
          cnt  <= 4'd15;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quot <= {quot[Q_W-2:0], ge};
        dsh  <= {1'b0, dsh[NUM_W-1:1]};
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 4'd1;
        end
      end
    end
  end

endmodule

// File: hw/rtl/best_shot_lane_selector_core.sv
// Words are taken one at a time; a single shared 35x21 multiplier and a
//   bit-serial divider do the arithmetic, with a bit-serial square root per lane.
// Reset: synchronous, active high; clears the sequencer, opponent count,
//   overflow flag and output valid, and loads the configuration defaults.
// ---------------------------------------------------------------------------
// Best shot lane selector core
// Picks the clearest lane from the ball to points across the goal mouth.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "best_shot_lane_selector_core_assert.svh"

module best_shot_lane_selector_core #(
  parameter int MAX_OPPONENTS  = 16,
  parameter int NUM_CANDIDATES = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] target_x,
  output logic signed [15:0] target_y,
  output logic [15:0]        clearance_mm,
  output logic [1:0]         status
);
  import bsls_pkg::*;

  localparam int CNT_W = $clog2(MAX_OPPONENTS + 1);
  localparam int IDX_W = (MAX_OPPONENTS > 1) ? $clog2(MAX_OPPONENTS) : 1;
  localparam int K_W   = (NUM_CANDIDATES > 1) ? $clog2(NUM_CANDIDATES) : 1;
  localparam int CX_W  = $clog2(32768 + 2048 + 1024 * NUM_CANDIDATES) + 2;

  localparam logic [4:0] S_IDLE = 5'd0,  S_LANE = 5'd1,  S_VV0  = 5'd2,  S_VV1  = 5'd3,
                         S_SQRT = 5'd4,  S_R2   = 5'd5,  S_R2VV = 5'd6,  S_OPP  = 5'd7,
                         S_DOT0 = 5'd8,  S_DOT1 = 5'd9,  S_CR0  = 5'd10, S_CR1  = 5'd11,
                         S_AC0  = 5'd12, S_AC1  = 5'd13, S_TEST = 5'd14, S_NUM  = 5'd15,
                         S_DIV  = 5'd16, S_LEND = 5'd17, S_DONE = 5'd18;

  // Configuration
  logic signed [15:0] goal_cx, goal_cy;
  logic [11:0]        goal_w;
  logic [9:0]         radius, step;

  // Opponent store
  logic signed [15:0] opp_x [MAX_OPPONENTS];
  logic signed [15:0] opp_y [MAX_OPPONENTS];
  logic [CNT_W-1:0]   count;
  logic               overflow;

  // Sequencer
  logic [4:0]         state, state_next;
  logic signed [15:0] bx, by, tx;
  logic signed [CX_W-1:0] cx;
  logic [K_W-1:0]     k;
  logic [CNT_W-1:0]   i;
  logic [33:0]        vv;
  logic [16:0]        s;
  logic [4:0]         sb;
  logic [19:0]        r2;
  logic [53:0]        r2vv;
  logic signed [34:0] dot, cr;
  logic [67:0]        acc;
  score_t             lane_best, best;
  logic               blocked, found;
  logic signed [15:0] best_x;

  // Shared multiplier
  logic signed [34:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [55:0] prod;

  logic signed [16:0] vx, vy, ex, ey;
  logic [33:0]        acr;
  logic [16:0]        trial;
  logic               vv_zero;
  logic signed [34:0] dsum;
  logic               div_done;
  score_t             div_q;
  logic               in_acc, out_load;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign vx = 17'(tx) - 17'(bx);
  assign vy = 17'(goal_cy) - 17'(by);
  assign ex = 17'(opp_x[i[IDX_W-1:0]]) - 17'(bx);
  assign ey = 17'(opp_y[i[IDX_W-1:0]]) - 17'(by);
  assign acr = cr[34] ? 34'(-cr) : cr[33:0];
  assign trial = s | (17'd1 << sb);
  assign vv_zero = (vv == 34'd0);
  assign dsum = dot + 35'(prod);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_VV0:  begin mul_a = 35'(vx); mul_b = 21'(vx); end
      S_VV1:  begin mul_a = 35'(vy); mul_b = 21'(vy); end
      S_SQRT: begin mul_a = {18'b0, trial}; mul_b = {4'b0, trial}; end
      S_R2:   begin mul_a = {25'b0, radius}; mul_b = {11'b0, radius}; end
      S_R2VV: begin mul_a = {1'b0, vv}; mul_b = {1'b0, r2}; end
      S_DOT0: begin mul_a = 35'(ex); mul_b = vv_zero ? 21'(ex) : 21'(vx); end
      S_DOT1: begin mul_a = 35'(ey); mul_b = vv_zero ? 21'(ey) : 21'(vy); end
      S_CR0:  begin mul_a = 35'(ex); mul_b = 21'(vy); end
      S_CR1:  begin mul_a = 35'(ey); mul_b = 21'(vx); end
      S_AC0:  begin mul_a = {1'b0, acr}; mul_b = {4'b0, acr[16:0]}; end
      S_AC1:  begin mul_a = {1'b0, acr}; mul_b = {4'b0, acr[33:17]}; end
      S_NUM:  begin mul_a = {1'b0, acr}; mul_b = {4'b0, s}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 56'(mul_a) * 56'(mul_b);

  bsls_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_NUM),
    .num   (prod[NUM_W-1:0]),
    .den   (dot),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_acc && opcode != OP_ADD) state_next = S_LANE;
      S_LANE: state_next = S_VV0;
      S_VV0:  state_next = S_VV1;
      S_VV1:  state_next = S_SQRT;
      S_SQRT: if (sb == 5'd0) state_next = S_R2;
      S_R2:   state_next = S_R2VV;
      S_R2VV: state_next = S_OPP;
      S_OPP:  state_next = (i == count) ? S_LEND : S_DOT0;
      S_DOT0: state_next = S_DOT1;
      S_DOT1: begin
        if (vv_zero) state_next = (dsum < 35'(r2)) ? S_LEND : S_OPP;
        else         state_next = dsum[34] ? S_OPP : S_CR0;
      end
      S_CR0:  state_next = S_CR1;
      S_CR1:  state_next = S_AC0;
      S_AC0:  state_next = S_AC1;
      S_AC1:  state_next = S_TEST;
      S_TEST: begin
        if (acc < 68'(r2vv))   state_next = S_LEND;
        else if (dot == '0)    state_next = S_OPP;
        else                   state_next = S_NUM;
      end
      S_NUM:  state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_OPP;
      S_LEND: state_next = (k == K_W'(NUM_CANDIDATES - 1)) ? S_DONE : S_LANE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
      goal_cx   <= 16'sd0;
      goal_cy   <= 16'sd4500;
      goal_w    <= 12'd1000;
      radius    <= 10'd112;
      step      <= 10'd50;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_GOAL_CENTER_X:   goal_cx <= cfg_data;
          CFG_GOAL_CENTER_Y:   goal_cy <= cfg_data;
          CFG_MOUTH_WIDTH:     goal_w  <= cfg_data[11:0];
          CFG_BLOCK_RADIUS_MM: radius  <= cfg_data[9:0];
          CFG_STEP_MM:         step    <= cfg_data[9:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (opcode == OP_ADD) begin
              if (count < CNT_W'(MAX_OPPONENTS)) begin
                opp_x[count[IDX_W-1:0]] <= pos_x;
                opp_y[count[IDX_W-1:0]] <= pos_y;
                count <= count + 1'b1;
              end else begin
                overflow <= 1'b1;
              end
            end else begin
              bx    <= pos_x;
              by    <= pos_y;
              k     <= '0;
              found <= 1'b0;
              cx    <= CX_W'(goal_cx) - CX_W'({1'b0, goal_w[11:1]})
                       + CX_W'({1'b0, step});
            end
          end
        end
        S_LANE: begin
          if (cx > CX_W'(32767))        tx <= 16'sh7FFF;
          else if (cx < -CX_W'(32768))  tx <= -16'sh8000;
          else                          tx <= cx[15:0];
          blocked   <= 1'b0;
          lane_best <= SCORE_MAX;
        end
        S_VV0: vv <= prod[33:0];
        S_VV1: begin
          vv <= vv + prod[33:0];
          s  <= '0;
          sb <= 5'd16;
        end
        S_SQRT: begin
          // One root bit a cycle: keep the bit when its square still fits.
          if (prod[34:0] <= {1'b0, vv}) s <= trial;
          sb <= sb - 5'd1;
        end
        S_R2:   r2   <= prod[19:0];
        S_R2VV: begin
          r2vv <= prod[53:0];
          i    <= '0;
        end
        S_DOT0: dot <= 35'(prod);
        S_DOT1: begin
          // With the ball on the target, the sum is the squared distance.
          dot <= dsum;
          if (vv_zero) begin
            if (dsum < 35'(r2)) blocked <= 1'b1;
            else i <= i + 1'b1;
          end else if (dsum[34]) begin
            i <= i + 1'b1;
          end
        end
        S_CR0: cr <= 35'(prod);
        S_CR1: cr <= cr - 35'(prod);
        S_AC0: acc <= 68'(prod[50:0]);
        S_AC1: acc <= acc + {prod[50:0], 17'b0};
        S_TEST: begin
          if (acc < 68'(r2vv)) blocked <= 1'b1;
          else if (dot == '0)  i <= i + 1'b1;
        end
        S_DIV: begin
          if (div_done) begin
            if (div_q < lane_best) lane_best <= div_q;
            i <= i + 1'b1;
          end
        end
        S_LEND: begin
          if (!blocked && (!found || lane_best > best)) begin
            best   <= lane_best;
            best_x <= tx;
            found  <= 1'b1;
          end
          k  <= k + 1'b1;
          cx <= cx + CX_W'({1'b0, step});
        end
        S_DONE: begin
          if (out_load) begin
            target_x     <= found ? best_x : goal_cx;
            target_y     <= goal_cy;
            clearance_mm <= found ? best : 16'd0;
            status       <= overflow ? STATUS_OVERFLOW :
                            (found ? STATUS_FOUND : STATUS_BLOCKED);
            count        <= '0;
            overflow     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `BSLS_ASSERT(a_word_from_done, $rose(out_valid) |-> $past(state) == S_DONE, "stray result")
  `BSLS_ASSERT(a_count_bound, count <= CNT_W'(MAX_OPPONENTS), "opponent count beyond store")
  `BSLS_ASSERT(a_store_cleared, out_load |=> count == '0 && !overflow, "store not cleared")

endmodule
